// ----- rtl/core/hsl_pkg.sv -----
// Shared types and constants for the HSL to RGB converter.
// Holds the pixel structs, the hue sector codes and the fixed-point constants.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package hsl_pkg;

   // One input beat: hue in degrees with four fraction bits, S and L with 256 as 1.0.
   typedef struct packed {
      logic [12:0] hue;
      logic [8:0]  saturation;
      logic [8:0]  lightness;
   } hsl_req_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } hsl_rsp_type;

   // Sixty-degree hue sectors, named after the colours they run between.
   typedef enum logic [2:0] {
      SECT_R_TO_Y = 3'd0,
      SECT_Y_TO_G = 3'd1,
      SECT_G_TO_C = 3'd2,
      SECT_C_TO_B = 3'd3,
      SECT_B_TO_M = 3'd4,
      SECT_M_TO_R = 3'd5
   } hsl_sector_type;

   // Classified item passed from the front end to the arithmetic back end.
   typedef struct packed {
      logic signed [9:0] span;       // 256 - |2l - 256|
      logic [8:0]        saturation;
      logic [8:0]        lightness;
      logic [9:0]        ramp;       // 960 - |(h mod 1920) - 960|
      hsl_sector_type    sector;
   } hsl_task_type;

   // Hue thresholds in sixteenths of a degree.
   localparam logic [12:0] HUE_60  = 13'd960;
   localparam logic [12:0] HUE_120 = 13'd1920;
   localparam logic [12:0] HUE_180 = 13'd2880;
   localparam logic [12:0] HUE_240 = 13'd3840;
   localparam logic [12:0] HUE_300 = 13'd4800;
   localparam logic [12:0] HUE_360 = 13'd5760;
   localparam logic [12:0] HUE_480 = 13'd7680;

   localparam logic [8:0]  L_HALF  = 9'd128;

   // A scaled channel of 256 * 960 or more saturates at full scale.
   localparam logic [22:0] SAT_LIMIT = 23'd245760;
   // floor((u + 1) * 4369 / 65536) equals floor(u / 15) for u below 3840.
   localparam logic [12:0] RECIP_15  = 13'd4369;

   // Queue depths; the result queue covers the back-end pipeline plus slack.
   localparam int MID_DEPTH = 2;
   localparam int MID_AW    = 1;
   localparam int OUT_DEPTH = 8;
   localparam int OUT_AW    = 3;

endpackage : hsl_pkg

`default_nettype wire

// ----- rtl/core/hsl_front.sv -----
// Front end of the HSL to RGB converter: accepts pixels, works out the hue
// sector, hue ramp and lightness span, and queues them for the back end.
// Depends on hsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsl_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   output logic                req_full,
   input  wire hsl_pkg::hsl_req_type req_pixel,
   output logic                task_valid,
   output hsl_pkg::hsl_task_type task_item,
   input  wire                 task_take
);
   import hsl_pkg::*;

   hsl_task_type         mid_mem_ff [MID_DEPTH];
   logic [MID_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [MID_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [MID_AW:0]      count_ff, count_in;

   hsl_task_type         task_new;
   logic [12:0]          hue_wrap;
   logic [10:0]          hue_mod;
   logic                 accept;
   logic                 take;

   // Classification of the incoming beat.
   always_comb begin
      priority if (req_pixel.hue >= HUE_480) begin
         hue_wrap = req_pixel.hue - HUE_480;
      end else if (req_pixel.hue >= HUE_360) begin
         hue_wrap = req_pixel.hue - HUE_360;
      end else if (req_pixel.hue >= HUE_240) begin
         hue_wrap = req_pixel.hue - HUE_240;
      end else if (req_pixel.hue >= HUE_120) begin
         hue_wrap = req_pixel.hue - HUE_120;
      end else begin
         hue_wrap = req_pixel.hue;
      end
      hue_mod = hue_wrap[10:0];

      priority if (req_pixel.hue < HUE_60) begin
         task_new.sector = SECT_R_TO_Y;
      end else if (req_pixel.hue < HUE_120) begin
         task_new.sector = SECT_Y_TO_G;
      end else if (req_pixel.hue < HUE_180) begin
         task_new.sector = SECT_G_TO_C;
      end else if (req_pixel.hue < HUE_240) begin
         task_new.sector = SECT_C_TO_B;
      end else if (req_pixel.hue < HUE_300) begin
         task_new.sector = SECT_B_TO_M;
      end else begin
         task_new.sector = SECT_M_TO_R;
      end

      if (hue_mod >= HUE_60[10:0]) begin
         task_new.ramp = 10'(HUE_120[10:0] - hue_mod);
      end else begin
         task_new.ramp = hue_mod[9:0];
      end

      // The span goes negative for lightness above 1.0; it wraps correctly in ten bits.
      if (req_pixel.lightness >= L_HALF) begin
         task_new.span = $signed(10'd512 - {req_pixel.lightness, 1'b0});
      end else begin
         task_new.span = $signed({req_pixel.lightness, 1'b0});
      end

      task_new.saturation = req_pixel.saturation;
      task_new.lightness  = req_pixel.lightness;
   end

   assign req_full   = (count_ff == (MID_AW+1)'(MID_DEPTH));
   assign accept     = req_push && !req_full;
   assign task_valid = (count_ff != '0);
   assign take       = task_take && task_valid;
   assign task_item  = mid_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_mem_ff[wr_ptr_ff] <= task_new;
      end
   end

endmodule : hsl_front

`default_nettype wire

// ----- rtl/core/hsl_back.sv -----
// Back end of the HSL to RGB converter: four-stage arithmetic pipeline
// (chroma, terms, channel sums, scaling) and the result queue.
// Depends on hsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsl_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  task_valid,
   input  wire hsl_pkg::hsl_task_type task_item,
   output logic                 task_take,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output hsl_pkg::hsl_rsp_type  rsp_pixel
);
   import hsl_pkg::*;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [11:0] quot_in;   // scaled value divided by 64, still to be divided by 15
   } hsl_prep_type;

   // Scaled channel times 255, floored by 2^17; the division by 960 finishes later.
   function automatic hsl_prep_type prep_channel(input logic signed [31:0] v);
      logic signed [39:0] prod;
      logic [22:0]        w;
      hsl_prep_type       r;
      prod      = (40'(v) <<< 8) - 40'(v);
      w         = prod[39:17];
      r.neg     = v[31];
      r.sat     = (w >= SAT_LIMIT);
      r.quot_in = w[17:6];
      return r;
   endfunction

   function automatic logic [7:0] finish_channel(input hsl_prep_type p);
      logic [12:0] u1;
      logic [25:0] prod;
      u1   = {1'b0, p.quot_in} + 13'd1;
      prod = 26'(u1) * 26'(RECIP_15);
      if (p.neg) begin
         return 8'd0;
      end else if (p.sat) begin
         return 8'hFF;
      end
      return prod[23:16];
   endfunction

   // Stage 1: chroma.
   logic                     mul_valid_ff;
   logic signed [18:0]       mul_chroma_ff, mul_chroma_in;
   logic [8:0]               mul_light_ff;
   logic [9:0]               mul_ramp_ff;
   hsl_sector_type           mul_sector_ff;
   logic signed [19:0]       mul_prod;

   // Stage 2: component and offset terms.
   logic                     term_valid_ff;
   logic signed [31:0]       term_c_ff, term_c_in;
   logic signed [31:0]       term_x_ff, term_x_in;
   logic signed [31:0]       term_m_ff, term_m_in;
   hsl_sector_type           term_sector_ff;
   logic signed [31:0]       chroma_w;
   logic signed [31:0]       light_w;
   logic signed [29:0]       x_prod;

   // Stage 3: channel sums.
   logic                     sum_valid_ff;
   logic signed [31:0]       sum_ff [3];
   logic signed [31:0]       sum_in [3];
   logic signed [31:0]       comp   [3];

   // Stage 4: scaling.
   logic                     scale_valid_ff;
   hsl_prep_type             scale_ff [3];
   hsl_rsp_type              rsp_new;

   // Result queue and credit count.
   hsl_rsp_type              out_mem_ff [OUT_DEPTH];
   logic [OUT_AW-1:0]        out_wr_ptr_ff, out_wr_ptr_in;
   logic [OUT_AW-1:0]        out_rd_ptr_ff, out_rd_ptr_in;
   logic [OUT_AW:0]          out_count_ff, out_count_in;
   logic [OUT_AW:0]          credit_ff, credit_in;
   logic                     pop;

   // Every beat in the pipeline already owns a queue slot, so the pipeline never stalls.
   assign task_take = task_valid && (credit_ff < (OUT_AW+1)'(OUT_DEPTH));
   assign pop       = rsp_pop && !rsp_empty;
   assign rsp_empty = (out_count_ff == '0);
   assign rsp_pixel = out_mem_ff[out_rd_ptr_ff];

   always_comb begin
      mul_prod      = task_item.span * $signed({1'b0, task_item.saturation});
      mul_chroma_in = mul_prod[18:0];

      chroma_w  = 32'(mul_chroma_ff);
      light_w   = $signed({23'd0, mul_light_ff});
      x_prod    = mul_chroma_ff * $signed({1'b0, mul_ramp_ff});
      term_c_in = (chroma_w <<< 11) - (chroma_w <<< 7);
      term_x_in = 32'(x_prod) <<< 1;
      term_m_in = ((light_w <<< 19) - (light_w <<< 15))
                - ((chroma_w <<< 10) - (chroma_w <<< 6));

      unique case (term_sector_ff)
         SECT_R_TO_Y: begin
            comp[0] = term_c_ff; comp[1] = term_x_ff; comp[2] = '0;
         end
         SECT_Y_TO_G: begin
            comp[0] = term_x_ff; comp[1] = term_c_ff; comp[2] = '0;
         end
         SECT_G_TO_C: begin
            comp[0] = '0; comp[1] = term_c_ff; comp[2] = term_x_ff;
         end
         SECT_C_TO_B: begin
            comp[0] = '0; comp[1] = term_x_ff; comp[2] = term_c_ff;
         end
         SECT_B_TO_M: begin
            comp[0] = term_x_ff; comp[1] = '0; comp[2] = term_c_ff;
         end
         SECT_M_TO_R: begin
            comp[0] = term_c_ff; comp[1] = '0; comp[2] = term_x_ff;
         end
         default: begin
            comp[0] = '0; comp[1] = '0; comp[2] = '0;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = comp[i] + term_m_ff;
      end

      rsp_new.red   = finish_channel(scale_ff[0]);
      rsp_new.green = finish_channel(scale_ff[1]);
      rsp_new.blue  = finish_channel(scale_ff[2]);
   end

   always_comb begin
      out_wr_ptr_in = scale_valid_ff ? out_wr_ptr_ff + 1'b1 : out_wr_ptr_ff;
      out_rd_ptr_in = pop ? out_rd_ptr_ff + 1'b1 : out_rd_ptr_ff;
      out_count_in  = out_count_ff;
      if (scale_valid_ff && !pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (pop && !scale_valid_ff) begin
         out_count_in = out_count_ff - 1'b1;
      end
      credit_in = credit_ff;
      if (task_take && !pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (pop && !task_take) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff   <= 1'b0;
         term_valid_ff  <= 1'b0;
         sum_valid_ff   <= 1'b0;
         scale_valid_ff <= 1'b0;
         out_wr_ptr_ff  <= '0;
         out_rd_ptr_ff  <= '0;
         out_count_ff   <= '0;
         credit_ff      <= '0;
      end else begin
         mul_valid_ff   <= task_take;
         term_valid_ff  <= mul_valid_ff;
         sum_valid_ff   <= term_valid_ff;
         scale_valid_ff <= sum_valid_ff;
         out_wr_ptr_ff  <= out_wr_ptr_in;
         out_rd_ptr_ff  <= out_rd_ptr_in;
         out_count_ff   <= out_count_in;
         credit_ff      <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_chroma_ff  <= mul_chroma_in;
      mul_light_ff   <= task_item.lightness;
      mul_ramp_ff    <= task_item.ramp;
      mul_sector_ff  <= task_item.sector;
      term_c_ff      <= term_c_in;
      term_x_ff      <= term_x_in;
      term_m_ff      <= term_m_in;
      term_sector_ff <= mul_sector_ff;
      for (int i = 0; i < 3; i++) begin
         sum_ff[i]   <= sum_in[i];
         scale_ff[i] <= prep_channel(sum_ff[i]);
      end
      if (scale_valid_ff) begin
         out_mem_ff[out_wr_ptr_ff] <= rsp_new;
      end
   end

endmodule : hsl_back

`default_nettype wire

// ----- rtl/core/hsl_to_rgb_converter.sv -----
// HSL to RGB converter, one RGB pixel for every HSL pixel.
// Input channel: a beat is taken at a rising edge with req_push high and
// req_full low; req_pixel carries hue (sixteenths of a degree), saturation
// and lightness (256 is full scale).
// Result channel: while rsp_empty is low, rsp_pixel holds the oldest result;
// it is taken at an edge with rsp_pop high.
// Throughput: one pixel per cycle while the receiver keeps popping results; the
// front end classifies the hue and lightness as it accepts a beat, the back end
// is a four-stage pipeline (chroma, terms, channel sums, scaling) feeding an
// eight-entry result queue.
// When the receiver stalls, the result queue fills, the back end stops
// drawing from the two-entry queue behind the front end, and req_full rises
// once that queue is full too. No beat is dropped.
// Reset empties both queues and the pipeline; no results are pending after it.
// Depends on hsl_pkg, hsl_front and hsl_back.
`timescale 1ns / 1ps
`default_nettype none

module hsl_to_rgb_converter (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_push,
   output logic                 req_full,
   input  wire hsl_pkg::hsl_req_type req_pixel,
   output logic                 rsp_empty,
   input  wire                  rsp_pop,
   output hsl_pkg::hsl_rsp_type  rsp_pixel
);
   import hsl_pkg::*;

   logic         task_valid;
   logic         task_take;
   hsl_task_type task_item;

   hsl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_pixel  (req_pixel),
      .task_valid (task_valid),
      .task_item  (task_item),
      .task_take  (task_take)
   );

   hsl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .task_valid (task_valid),
      .task_item  (task_item),
      .task_take  (task_take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_pixel  (rsp_pixel)
   );

endmodule : hsl_to_rgb_converter

`default_nettype wire
